[rtl/bmrd_pkg.sv]
// Package for the battery monitor readback decoder.
// Holds shared types, codes and the sample conversion functions; no dependencies.
package bmrd_pkg;

  localparam int MAX_DEVICES_DEF = 16;
  localparam int MAX_RES         = 3;

  localparam logic [1:0] MODE_CELL = 2'd0;
  localparam logic [1:0] MODE_TEMP = 2'd1;
  localparam logic [1:0] MODE_CONF = 2'd2;
  localparam logic [1:0] MODE_DIAG = 2'd3;

  localparam logic REG_MODE   = 1'b0;
  localparam logic REG_DEVCNT = 1'b1;

  localparam logic [2:0] KIND_CELL  = 3'd0;
  localparam logic [2:0] KIND_NCT   = 3'd1;
  localparam logic [2:0] KIND_CT    = 3'd2;
  localparam logic [2:0] KIND_INT   = 3'd3;
  localparam logic [2:0] KIND_RAW   = 3'd4;

  localparam logic [2:0] CONF_LEN   = 3'd6;
  localparam logic [2:0] DIAG_LEN   = 3'd2;
  localparam logic [2:0] CELL_GRPS  = 3'd5;
  localparam logic [2:0] TEMP_BYTES = 3'd4;

  localparam logic [15:0] OFFS_512  = 16'd512;
  localparam logic [11:0] TEMP_OFFS = 12'd58;
  localparam logic [15:0] TEMP_BASE = 16'd114;
  localparam logic [15:0] KELVIN    = 16'd273;
  localparam logic [23:0] RECIP17   = 24'd3856;

  typedef struct packed {
    logic [1:0] mode;
    logic [4:0] dev_cnt;
    logic       mode_wr;
  } cfg_t;

  typedef struct packed {
    logic [15:0] value;
    logic [2:0]  kind;
    logic [3:0]  device;
    logic [3:0]  channel;
    logic        last;
    logic        done;
  } res_t;

  typedef struct packed {
    logic                 load;
    logic [1:0]           cnt;
    res_t [MAX_RES-1:0]   res;
  } dec_out_t;

  function automatic logic [15:0] cell_scale(input logic [11:0] v);
    logic [15:0] u;
    u = 16'(v) - OFFS_512;
    return u + (u >> 1);
  endfunction

  function automatic logic [15:0] ext_temp(input logic [11:0] t);
    logic        neg;
    logic [11:0] m;
    logic [23:0] p;
    logic [7:0]  q;
    neg = t > TEMP_OFFS;
    m   = neg ? (t - TEMP_OFFS) : (TEMP_OFFS - t);
    p   = 24'(m) * RECIP17;
    q   = p[23:16];
    return neg ? (TEMP_BASE - 16'(q)) : (TEMP_BASE + 16'(q));
  endfunction

  function automatic logic [15:0] int_temp(input logic [11:0] t);
    logic [15:0] u;
    logic [15:0] u3;
    u  = 16'(t) - OFFS_512;
    u3 = u + (u << 1);
    return (u3 >> 4) - KELVIN;
  endfunction

endpackage

[rtl/bmrd_cfg.sv]
// Configuration registers of the readback decoder on an APB-style port.
// Depends on bmrd_pkg.
module bmrd_cfg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [2:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready,
  output bmrd_pkg::cfg_t     cfg
);

  logic [1:0] mode_r;
  logic [4:0] dev_cnt_r;
  logic       wr;

  assign cfg_pready = 1'b1;
  assign wr = cfg_psel && cfg_penable && cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= bmrd_pkg::MODE_CELL;
      dev_cnt_r <= 5'd1;
    end else if (wr) begin
      unique case (cfg_paddr[2])
        bmrd_pkg::REG_MODE:   mode_r    <= cfg_pwdata[1:0];
        bmrd_pkg::REG_DEVCNT: dev_cnt_r <= cfg_pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_paddr[2])
      bmrd_pkg::REG_MODE:   cfg_prdata = {30'd0, mode_r};
      bmrd_pkg::REG_DEVCNT: cfg_prdata = {27'd0, dev_cnt_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  assign cfg.mode    = mode_r;
  assign cfg.dev_cnt = dev_cnt_r;
  assign cfg.mode_wr = wr && (cfg_paddr[2] == bmrd_pkg::REG_MODE);

endmodule

[rtl/bmrd_decode.sv]
// Input register, frame counters and single-pass byte decode.
// Depends on bmrd_pkg.
module bmrd_decode #(
  parameter int MAX_DEVICES = bmrd_pkg::MAX_DEVICES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [7:0]           in_byte,
  input  logic                 in_start,
  input  bmrd_pkg::cfg_t       cfg,
  input  logic                 can_load,
  output bmrd_pkg::dec_out_t   dec
);

  localparam int DW = $clog2(MAX_DEVICES + 1);
  localparam int CW = (DW > 5) ? DW : 5;

  logic          in_v_r;
  logic [7:0]    rx_r;
  logic          fs_r;
  logic          go;

  logic [2:0]    bp_r, bp_nxt, bp;
  logic [2:0]    gi_r, gi_nxt, gi;
  logic [DW-1:0] di_r, di_nxt, di;
  logic          fin_r, fin_nxt, fin;
  logic [7:0]    held_r [4];
  logic          hold_we;

  logic [CW-1:0] dc;
  logic [CW:0]   di_inc;
  logic          skip;
  logic          lastdev;
  logic [3:0]    dev4;
  logic [2:0]    len;
  logic [11:0]   v0, v1, t0, t1, t2;
  bmrd_pkg::res_t [bmrd_pkg::MAX_RES-1:0] res;
  logic [1:0]    cnt;

  assign go        = in_v_r && can_load;
  assign in_tready = !in_v_r || go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_tready) begin
      in_v_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      rx_r <= in_byte;
      fs_r <= in_start;
    end
  end

  always_comb begin
    if (CW'(cfg.dev_cnt) > CW'(MAX_DEVICES)) begin
      dc = CW'(MAX_DEVICES);
    end else begin
      dc = CW'(cfg.dev_cnt);
    end
  end

  always_comb begin
    bp  = fs_r ? 3'd0 : bp_r;
    gi  = fs_r ? 3'd0 : gi_r;
    di  = fs_r ? '0 : di_r;
    fin = fs_r ? 1'b0 : fin_r;

    di_inc  = (CW + 1)'(di) + (CW + 1)'(1);
    skip    = fin || (CW'(di) >= dc);
    lastdev = di_inc == (CW + 1)'(dc);
    dev4    = 4'(di);
    len     = (cfg.mode == bmrd_pkg::MODE_CONF) ? bmrd_pkg::CONF_LEN : bmrd_pkg::DIAG_LEN;

    v0 = {held_r[1][3:0], held_r[0]};
    v1 = {rx_r, held_r[1][7:4]};
    t0 = {held_r[1][3:0], held_r[0]};
    t1 = {held_r[2], held_r[1][7:4]};
    t2 = {rx_r[3:0], held_r[3]};

    bp_nxt  = bp;
    gi_nxt  = gi;
    di_nxt  = di;
    fin_nxt = fin;
    hold_we = 1'b0;
    cnt     = 2'd0;
    for (int k = 0; k < bmrd_pkg::MAX_RES; k++) begin
      res[k].value   = 16'd0;
      res[k].kind    = bmrd_pkg::KIND_RAW;
      res[k].device  = dev4;
      res[k].channel = 4'd0;
      res[k].last    = 1'b0;
      res[k].done    = 1'b0;
    end

    if (!skip) begin
      unique case (cfg.mode)
        bmrd_pkg::MODE_CELL: begin
          priority if (gi >= bmrd_pkg::CELL_GRPS) begin
            bp_nxt  = 3'd0;
            gi_nxt  = 3'd0;
            di_nxt  = DW'(di_inc);
            fin_nxt = di_inc >= (CW + 1)'(dc);
          end else if (bp < 3'd2) begin
            hold_we = 1'b1;
            bp_nxt  = bp + 3'd1;
          end else begin
            cnt            = 2'd2;
            res[0].value   = bmrd_pkg::cell_scale(v0);
            res[0].kind    = bmrd_pkg::KIND_CELL;
            res[0].channel = 4'({gi, 1'b0});
            res[1].value   = bmrd_pkg::cell_scale(v1);
            res[1].kind    = bmrd_pkg::KIND_CELL;
            res[1].channel = 4'({gi, 1'b1});
            res[1].last    = 1'b1;
            res[1].done    = (gi == 3'd4) && lastdev;
            bp_nxt         = 3'd0;
            gi_nxt         = gi + 3'd1;
          end
        end
        bmrd_pkg::MODE_TEMP: begin
          priority if (bp < bmrd_pkg::TEMP_BYTES) begin
            hold_we = 1'b1;
            bp_nxt  = bp + 3'd1;
          end else if (bp == bmrd_pkg::TEMP_BYTES) begin
            cnt            = 2'd3;
            res[0].value   = bmrd_pkg::ext_temp(t0);
            res[0].kind    = bmrd_pkg::KIND_NCT;
            res[0].channel = 4'd0;
            res[1].value   = bmrd_pkg::ext_temp(t1);
            res[1].kind    = bmrd_pkg::KIND_CT;
            res[1].channel = 4'd1;
            res[2].value   = bmrd_pkg::int_temp(t2);
            res[2].kind    = bmrd_pkg::KIND_INT;
            res[2].channel = 4'd2;
            res[2].last    = 1'b1;
            res[2].done    = lastdev;
            bp_nxt         = 3'd5;
          end else begin
            bp_nxt  = 3'd0;
            gi_nxt  = 3'd0;
            di_nxt  = DW'(di_inc);
            fin_nxt = di_inc >= (CW + 1)'(dc);
          end
        end
        bmrd_pkg::MODE_CONF, bmrd_pkg::MODE_DIAG: begin
          priority if (bp < len) begin
            cnt            = 2'd1;
            res[0].value   = {8'd0, rx_r};
            res[0].kind    = bmrd_pkg::KIND_RAW;
            res[0].channel = 4'(bp);
            res[0].last    = 1'b1;
            res[0].done    = ((bp + 3'd1) == len) && lastdev;
            bp_nxt         = bp + 3'd1;
          end else begin
            bp_nxt  = 3'd0;
            gi_nxt  = 3'd0;
            di_nxt  = DW'(di_inc);
            fin_nxt = di_inc >= (CW + 1)'(dc);
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bp_r  <= 3'd0;
      gi_r  <= 3'd0;
      di_r  <= '0;
      fin_r <= 1'b0;
    end else if (cfg.mode_wr) begin
      bp_r  <= 3'd0;
      gi_r  <= 3'd0;
      di_r  <= '0;
      fin_r <= 1'b0;
    end else if (go) begin
      bp_r  <= bp_nxt;
      gi_r  <= gi_nxt;
      di_r  <= di_nxt;
      fin_r <= fin_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (go && hold_we) begin
      held_r[bp[1:0]] <= rx_r;
    end
  end

  assign dec.load = go;
  assign dec.cnt  = cnt;
  assign dec.res  = res;

endmodule

[rtl/bmrd_outq.sv]
// Result register bank that holds up to three results of one byte and drains them in order.
// Depends on bmrd_pkg.
module bmrd_outq (
  input  logic                 clk,
  input  logic                 rst_n,
  input  bmrd_pkg::dec_out_t   dec,
  output logic                 can_load,
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output bmrd_pkg::res_t       out_res
);

  bmrd_pkg::res_t [bmrd_pkg::MAX_RES-1:0] q_r;
  logic [1:0] left_r;
  logic       fire;

  assign out_tvalid = left_r != 2'd0;
  assign fire       = out_tvalid && out_tready;
  assign can_load   = (left_r == 2'd0) || ((left_r == 2'd1) && out_tready);
  assign out_res    = q_r[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      left_r <= 2'd0;
    end else if (dec.load) begin
      left_r <= dec.cnt;
    end else if (fire) begin
      left_r <= left_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (dec.load) begin
      q_r <= dec.res;
    end else if (fire) begin
      q_r[0] <= q_r[1];
      q_r[1] <= q_r[2];
    end
  end

`ifndef SYNTHESIS
  a_load_free: assert property (@(posedge clk) disable iff (!rst_n)
    dec.load |-> (left_r == 2'd0) || ((left_r == 2'd1) && fire))
    else $error("result bank loaded while results pending");
  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && !dec.load) |=> left_r == $past(left_r) - 2'd1)
    else $error("result count did not advance on transaction");
  a_last_tail: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (q_r[0].last == (left_r == 2'd1)))
    else $error("last flag not on final result of a byte");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r != 2'd0 |-> left_r <= 2'(bmrd_pkg::MAX_RES))
    else $error("result count out of range");
`endif

endmodule

[rtl/battery_monitor_readback_decoder_top.sv]
// Battery monitor readback decoder: top level.
// Depends on bmrd_pkg, bmrd_cfg, bmrd_decode and bmrd_outq.
//
// Usage:
//   in_*  : one received response byte per transaction; in_tuser[0] marks the
//           first byte of a response and clears the frame counters.
//   out_* : decoded results, one per transaction; out_tlast closes the results
//           of one byte, out_tuser holds the result kind and flags the final
//           result of the response.
//   cfg_* : APB-style port, frame_mode at 0x0, device_count at 0x4; write only
//           while the block is idle. A frame_mode write restarts the response.
// Path: a byte is registered in the input register, decoded from there into
//   the result bank once the bank can take it, and offered from that bank.
// Throughput: one byte per cycle while out_tready is high and each byte gives
//   at most one result; a byte giving two or three results holds the input
//   until all but its last are taken; all share the one result bank and output.
// Reset: counters cleared, frame_mode 0, device_count 1, no results pending.
// Stall: while out_tready is low results hold; one more byte is taken into the
//   input register, then in_tready drops until the bank drains.
module battery_monitor_readback_decoder_top #(
  parameter int MAX_DEVICES = bmrd_pkg::MAX_DEVICES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  input  logic [0:0]  in_tuser,   // [0] frame_start
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [15:0] value, [19:16] device, [23:20] channel
  output logic        out_tlast,
  output logic [3:0]  out_tuser,  // [2:0] kind, [3] response_done
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  bmrd_pkg::cfg_t     cfg;
  bmrd_pkg::dec_out_t dec;
  bmrd_pkg::res_t     out_res;
  logic               can_load;

  bmrd_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .cfg         (cfg)
  );

  bmrd_decode #(
    .MAX_DEVICES (MAX_DEVICES)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_byte   (in_tdata),
    .in_start  (in_tuser[0]),
    .cfg       (cfg),
    .can_load  (can_load),
    .dec       (dec)
  );

  bmrd_outq u_outq (
    .clk        (clk),
    .rst_n      (rst_n),
    .dec        (dec),
    .can_load   (can_load),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_res    (out_res)
  );

  assign out_tdata = {out_res.channel, out_res.device, out_res.value};
  assign out_tlast = out_res.last;
  assign out_tuser = {out_res.done, out_res.kind};

endmodule
